>>> rtl/markov_chain_trajectory_step_assert.svh
// Assertion macros used by the checker file
`ifndef MARKOV_CHAIN_TRAJECTORY_STEP_ASSERT_SVH
`define MARKOV_CHAIN_TRAJECTORY_STEP_ASSERT_SVH

// Check at every clock edge, reset included
`define MCTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only
`define MCTS_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/mcts_pkg.sv
package mcts_pkg;

    localparam int NUM_STATES = 256;
    localparam int MAX_SLOTS  = 16;
    localparam int NUM_TRAJ   = 1024;

    localparam int STATE_W = 8;
    localparam int SLOT_W  = 4;
    localparam int TRAJ_W  = 10;
    localparam int THR_W   = 33;
    localparam int DRAW_W  = 32;
    localparam int VEL_W   = 32;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 5;

    localparam int TBL_AW    = STATE_W + SLOT_W;
    localparam int TBL_W     = THR_W + STATE_W;
    localparam int TBL_DEPTH = NUM_STATES * MAX_SLOTS;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        CMD_WRITE_SLOT = 2'd0,
        CMD_WRITE_VEL  = 2'd1,
        CMD_SET_TRAJ   = 2'd2,
        CMD_ADVANCE    = 2'd3
    } cmd_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_START = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_VEL   = 6'b010000,
        ST_WB    = 6'b100000
    } seq_state_t;

endpackage

>>> rtl/mcts_ram.sv
module mcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/markov_chain_trajectory_step.sv
// Writes (slot, velocity, set start state) are taken in IDLE, which the block keeps.
// Advance: START reads row 0 of the current state, then SCAN tests one slot per cycle,
// going to VEL and then WB when slot j is taken, or to WB after the last of the n slots
// (straight from START when n is zero); WB waits while an earlier result is stalled.
// The next transaction is taken once the result is registered and the block is in IDLE.
// Reset is asynchronous; a clearing pass then zeroes every sum, taking no transaction.
module markov_chain_trajectory_step
    import mcts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [TRAJ_W-1:0]         traj,
    input  logic [STATE_W-1:0]        state_index,
    input  logic [SLOT_W-1:0]         slot,
    input  logic [THR_W-1:0]          threshold,
    input  logic [STATE_W-1:0]        target_state,
    input  logic signed [VEL_W-1:0]   velocity,
    input  logic [DRAW_W-1:0]         rand_draw,
    input  logic                      clear_sum,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [TRAJ_W-1:0]         out_traj,
    output logic [STATE_W-1:0]        new_state,
    output logic                      moved,
    output logic signed [SUM_W-1:0]   displacement,
    output logic                      saturated
);

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]   slots_in_use_reg;
    logic [TRAJ_W-1:0]  clr_idx_reg;
    logic [TRAJ_W-1:0]  traj_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               clr_reg;
    logic [STATE_W-1:0] cur_st_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               moved_reg;
    logic               sat_reg;

    logic                out_valid_reg;
    logic [TRAJ_W-1:0]   out_traj_reg;
    logic [STATE_W-1:0]  new_state_reg;
    logic                moved_out_reg;
    logic [SUM_W-1:0]    disp_reg;
    logic                sat_out_reg;

    cmd_t               cmd_in;
    logic               in_fire;
    logic               st_ok;
    logic               slot_ok;
    logic               tgt_ok;
    logic               traj_ok;
    logic [CFG_W-1:0]   n_slots;
    logic               wb_go;
    logic               hit;
    logic               last_slot;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               sat_hi;
    logic               sat_lo;

    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_raddr;
    logic [TBL_W-1:0]    tbl_rdata;
    logic                vel_we;
    logic [VEL_W-1:0]    vel_rdata;
    logic                ts_we;
    logic [TRAJ_W-1:0]   ts_waddr;
    logic [STATE_W-1:0]  ts_wdata;
    logic [STATE_W-1:0]  ts_rdata;
    logic                sum_we;
    logic [TRAJ_W-1:0]   sum_waddr;
    logic [SUM_W-1:0]    sum_wdata;
    logic [SUM_W-1:0]    sum_rdata;

    // Decode the incoming transaction
    assign cmd_in   = cmd_t'(cmd);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign st_ok    = {1'b0, state_index} < (STATE_W+1)'(NUM_STATES);
    assign slot_ok  = {1'b0, slot} < (SLOT_W+1)'(MAX_SLOTS);
    assign tgt_ok   = {1'b0, target_state} < (STATE_W+1)'(NUM_STATES);
    assign traj_ok  = {1'b0, traj} < (TRAJ_W+1)'(NUM_TRAJ);

    // Clamp the slot count to the table size
    assign n_slots = (slots_in_use_reg > CFG_W'(MAX_SLOTS)) ? CFG_W'(MAX_SLOTS)
                                                           : slots_in_use_reg;

    // Compare the draw against the slot just read
    assign hit       = {1'b0, draw_reg} < tbl_rdata[TBL_W-1 -: THR_W];
    assign last_slot = (CFG_W'(k_reg) + CFG_W'(1)) == n_slots;

    // Add the velocity and clamp to the 48-bit range
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-VEL_W){vel_rdata[VEL_W-1]}}, vel_rdata};
    assign sat_hi   = !sum_wide[SUM_W] && sum_wide[SUM_W-1];
    assign sat_lo   = sum_wide[SUM_W] && !sum_wide[SUM_W-1];
    always_comb
    begin
        sum_sat = sum_wide[SUM_W-1:0];
        if (sat_hi)
        begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end
    end

    assign wb_go = (state_reg == ST_WB) && (!out_valid_reg || out_ready);

    // Transition memory: threshold over target, one row of slots per state
    assign tbl_we    = in_fire && (cmd_in == CMD_WRITE_SLOT) && st_ok && slot_ok && tgt_ok;
    assign tbl_raddr = (state_reg == ST_START) ? {ts_rdata, {SLOT_W{1'b0}}}
                                               : {cur_st_reg, k_reg + SLOT_W'(1)};

    mcts_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr ({state_index, slot}),
        .wdata ({threshold, target_state}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Velocity memory, read at the target of the slot under test
    assign vel_we = in_fire && (cmd_in == CMD_WRITE_VEL) && st_ok;

    mcts_ram #(.WIDTH(VEL_W), .DEPTH(NUM_STATES)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (state_index),
        .wdata (velocity),
        .raddr (tbl_rdata[STATE_W-1:0]),
        .rdata (vel_rdata)
    );

    // Trajectory state memory
    assign ts_we    = (in_fire && (cmd_in == CMD_SET_TRAJ) && traj_ok && st_ok)
                    || (wb_go && moved_reg);
    assign ts_waddr = wb_go ? traj_reg : traj;
    assign ts_wdata = wb_go ? cur_st_reg : state_index;

    mcts_ram #(.WIDTH(STATE_W), .DEPTH(NUM_TRAJ)) u_ts_ram (
        .clk   (clk),
        .we    (ts_we),
        .waddr (ts_waddr),
        .wdata (ts_wdata),
        .raddr (traj),
        .rdata (ts_rdata)
    );

    // Displacement sum memory, zeroed by the pass after reset
    assign sum_we    = (state_reg == ST_CLEAR)
                     || (in_fire && (cmd_in == CMD_SET_TRAJ) && traj_ok && st_ok)
                     || wb_go;
    assign sum_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : (wb_go ? traj_reg : traj);
    assign sum_wdata = wb_go ? sum_reg : '0;

    mcts_ram #(.WIDTH(SUM_W), .DEPTH(NUM_TRAJ)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (traj),
        .rdata (sum_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == TRAJ_W'(NUM_TRAJ - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && (cmd_in == CMD_ADVANCE) && traj_ok)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (n_slots == '0) ? ST_WB : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_VEL;
                end
                else if (last_slot)
                begin
                    state_next = ST_WB;
                end
            end
            ST_VEL:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            slots_in_use_reg <= SLOTS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + TRAJ_W'(1);
            end
            if (cfg_we)
            begin
                slots_in_use_reg <= cfg_wdata;
            end
            if (wb_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                traj_reg <= traj;
                draw_reg <= rand_draw;
                clr_reg  <= clear_sum;
            end
            ST_START:
            begin
                cur_st_reg <= ts_rdata;
                sum_reg    <= clr_reg ? '0 : sum_rdata;
                k_reg      <= '0;
                moved_reg  <= 1'b0;
                sat_reg    <= 1'b0;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    cur_st_reg <= tbl_rdata[STATE_W-1:0];
                    moved_reg  <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + SLOT_W'(1);
                end
            end
            ST_VEL:
            begin
                sum_reg <= sum_sat;
                sat_reg <= sat_hi || sat_lo;
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    out_traj_reg  <= traj_reg;
                    new_state_reg <= cur_st_reg;
                    moved_out_reg <= moved_reg;
                    disp_reg      <= sum_reg;
                    sat_out_reg   <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_traj     = out_traj_reg;
    assign new_state    = new_state_reg;
    assign moved        = moved_out_reg;
    assign displacement = disp_reg;
    assign saturated    = sat_out_reg;

endmodule

>>> rtl/mcts_checker.sv
`include "markov_chain_trajectory_step_assert.svh"

module mcts_checker
    import mcts_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [1:0]                cmd,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [TRAJ_W-1:0]         out_traj,
    input logic [STATE_W-1:0]        new_state,
    input logic                      moved,
    input logic signed [SUM_W-1:0]   displacement,
    input logic                      saturated
);

    // Nothing taken or offered while in reset
    `MCTS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !in_ready && !out_valid, "active during reset")

    // An accepted advance occupies the block on the next cycle
    `MCTS_ASSERT_RUN(a_advance_busy, in_valid && in_ready && cmd == CMD_ADVANCE |=> !in_ready, "ready after advance")

    // A trajectory that stays put cannot have clamped its sum
    `MCTS_ASSERT_RUN(a_no_move_no_sat, out_valid && !moved |-> !saturated, "saturated without a move")

    // Hold a stalled result
    `MCTS_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_traj) && $stable(new_state) && $stable(displacement), "result changed while stalled")

endmodule

bind markov_chain_trajectory_step mcts_checker u_mcts_checker (.*);
